FILE: hdl/lzss_pkg.sv
// Shared constants, types and codes for the LZSS stream decompressor.
package lzss_pkg;

	localparam int WIN_DEPTH  = 4096;
	localparam int WIN_AW     = $clog2(WIN_DEPTH);
	localparam int SIZE_BITS  = 24;
	localparam int LEN_BITS   = 5;
	localparam int LEN_BIAS   = 2;
	localparam int FLAG_COUNT = 8;
	localparam int FLAGS_W    = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic {
		CMD_LIT  = 1'b0,
		CMD_COPY = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [7:0]            lit;
		logic [LEN_BITS-1:0]   len;
		logic [WIN_AW-1:0]     back_dist;
	} cmd_t;

	typedef enum logic [1:0] {
		B_FETCH = 2'd0,
		B_READ  = 2'd1,
		B_EMIT  = 2'd2
	} back_state_t;

endpackage

FILE: hdl/lzss_in_if.sv
// Compressed byte channel: valid/ready handshake with one byte per beat.
interface lzss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] comp_byte;

	modport source (output valid, output comp_byte, input ready);
	modport sink (input valid, input comp_byte, output ready);
endinterface

FILE: hdl/lzss_out_if.sv
// Decompressed byte channel: valid/ready handshake with byte and status flags.
interface lzss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_done;
	logic       bad_distance;

	modport source (output valid, output out_byte, output run_last, output stream_done,
		output bad_distance, input ready);
	modport sink (input valid, input out_byte, input run_last, input stream_done,
		input bad_distance, output ready);
endinterface

FILE: hdl/lzss_front.sv
// Front end: parses marker, literal and token bytes into literal and copy commands.
module lzss_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flush,
	lzss_in_if.sink            comp,
	output logic               push,
	output lzss_pkg::cmd_t     push_cmd,
	input  logic               full
);

	logic [7:0]                     flag_bits_q;
	logic [lzss_pkg::FLAGS_W-1:0]   flags_left_q;
	logic                           token_phase_q;
	logic [7:0]                     token_low_q;
	logic                           beat;
	logic                           is_marker;
	logic                           is_lit;
	logic                           is_tok_hi;

	assign comp.ready = !full;
	assign beat       = comp.valid && comp.ready;
	assign is_marker  = (flags_left_q == '0);
	assign is_lit     = !is_marker && flag_bits_q[0];
	assign is_tok_hi  = !is_marker && !flag_bits_q[0] && token_phase_q;

	assign push = beat && (is_lit || is_tok_hi);

	always_comb begin
		push_cmd.kind      = is_lit ? lzss_pkg::CMD_LIT : lzss_pkg::CMD_COPY;
		push_cmd.lit       = comp.comp_byte;
		push_cmd.len       = lzss_pkg::LEN_BITS'(token_low_q[3:0]) +
			lzss_pkg::LEN_BITS'(lzss_pkg::LEN_BIAS);
		push_cmd.back_dist = {comp.comp_byte, token_low_q[7:4]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_bits_q   <= '0;
			flags_left_q  <= '0;
			token_phase_q <= 1'b0;
			token_low_q   <= '0;
		end else if (flush) begin
			flag_bits_q   <= '0;
			flags_left_q  <= '0;
			token_phase_q <= 1'b0;
			token_low_q   <= '0;
		end else if (beat) begin
			if (is_marker) begin
				flag_bits_q  <= comp.comp_byte;
				flags_left_q <= lzss_pkg::FLAGS_W'(lzss_pkg::FLAG_COUNT);
			end else if (is_lit || is_tok_hi) begin
				flag_bits_q   <= flag_bits_q >> 1;
				flags_left_q  <= flags_left_q - 1'b1;
				token_phase_q <= 1'b0;
			end else begin
				token_low_q   <= comp.comp_byte;
				token_phase_q <= 1'b1;
			end
		end
	end

endmodule

FILE: hdl/lzss_cmd_fifo.sv
// Short command queue between the parser and the copy engine.
module lzss_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flush,
	input  logic               push,
	input  lzss_pkg::cmd_t     push_cmd,
	output logic               full,
	input  logic               pop,
	output lzss_pkg::cmd_t     head,
	output logic               empty
);

	lzss_pkg::cmd_t                 slot_q [lzss_pkg::FIFO_DEPTH];
	logic [lzss_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [lzss_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [lzss_pkg::FIFO_AW:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (count_q == (lzss_pkg::FIFO_AW+1)'(lzss_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/lzss_back.sv
// Back end: runs literal and copy commands against the history window and drives output.
module lzss_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lzss_pkg::SIZE_BITS-1:0]    cfg_wdata,
	input  lzss_pkg::cmd_t                    head,
	input  logic                              empty,
	output logic                              pop,
	lzss_out_if.source                        dout
);

	lzss_pkg::back_state_t             state_q, state_d;
	lzss_pkg::cmd_t                    cmd_q;
	logic [lzss_pkg::LEN_BITS-1:0]     remain_q;
	logic [lzss_pkg::WIN_AW-1:0]       ptr_q;
	logic [lzss_pkg::SIZE_BITS-1:0]    bw_q;
	logic [lzss_pkg::SIZE_BITS-1:0]    size_q;
	logic                              bad_q;
	logic [7:0]                        win_mem [lzss_pkg::WIN_DEPTH];
	logic [7:0]                        rdata_q;
	logic [lzss_pkg::WIN_AW-1:0]       rd_addr;
	logic [lzss_pkg::SIZE_BITS-1:0]    bw_inc;
	logic [lzss_pkg::SIZE_BITS-1:0]    dist_ext;
	logic                              done;
	logic                              out_free;
	logic                              emit;
	logic                              last;
	logic                              take;
	logic [7:0]                        cur_byte;
	logic                              bad_now;

	logic                              out_valid_q;
	logic [7:0]                        out_byte_q;
	logic                              out_last_q;
	logic                              out_done_q;
	logic                              out_bad_q;

	assign done     = (bw_q == size_q);
	assign bw_inc   = bw_q + 1'b1;
	assign dist_ext = {{(lzss_pkg::SIZE_BITS-lzss_pkg::WIN_AW){1'b0}}, cmd_q.back_dist};
	assign rd_addr  = ptr_q - cmd_q.back_dist;
	assign bad_now  = (cmd_q.back_dist == '0) || (dist_ext > bw_q);
	assign out_free = !out_valid_q || dout.ready;
	assign cur_byte = (cmd_q.kind == lzss_pkg::CMD_LIT) ? cmd_q.lit :
		(bad_q ? 8'd0 : rdata_q);
	assign last     = (cmd_q.kind == lzss_pkg::CMD_LIT) ||
		(remain_q == lzss_pkg::LEN_BITS'(1)) || (bw_inc == size_q);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		take    = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			lzss_pkg::B_FETCH: begin
				if (!empty) begin
					pop = 1'b1;
					// drop commands once the stream is complete
					if (!done) begin
						take    = 1'b1;
						state_d = (head.kind == lzss_pkg::CMD_LIT) ?
							lzss_pkg::B_EMIT : lzss_pkg::B_READ;
					end
				end
			end
			lzss_pkg::B_READ: begin
				state_d = lzss_pkg::B_EMIT;
			end
			lzss_pkg::B_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = last ? lzss_pkg::B_FETCH : lzss_pkg::B_READ;
				end
			end
			default: begin
				state_d = lzss_pkg::B_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			win_mem[ptr_q] <= cur_byte;
		end
		if (state_q == lzss_pkg::B_READ) begin
			rdata_q <= win_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q    <= head;
			remain_q <= head.len;
		end else if (emit) begin
			remain_q <= remain_q - 1'b1;
		end
		if (take) begin
			bad_q <= 1'b0;
		end else if (state_q == lzss_pkg::B_READ) begin
			bad_q <= bad_now;
		end
		if (emit) begin
			out_byte_q <= cur_byte;
			out_last_q <= last;
			out_done_q <= (bw_inc == size_q);
			out_bad_q  <= (cmd_q.kind == lzss_pkg::CMD_COPY) && bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzss_pkg::B_FETCH;
			ptr_q       <= '0;
			bw_q        <= '0;
			size_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_we) begin
			state_q <= lzss_pkg::B_FETCH;
			ptr_q   <= '0;
			bw_q    <= '0;
			size_q  <= cfg_wdata;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ptr_q       <= ptr_q + 1'b1;
				bw_q        <= bw_inc;
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.out_byte     = out_byte_q;
	assign dout.run_last     = out_last_q;
	assign dout.stream_done  = out_done_q;
	assign dout.bad_distance = out_bad_q;

endmodule

FILE: hdl/lzss_stream_decompressor.sv
// Top level of the LZSS stream decompressor with a 4096-byte history window.
//
// comp carries one compressed byte per beat; dout carries one decompressed
// byte per beat with run_last, stream_done and bad_distance. Write the
// expected output size on cfg_we/cfg_wdata while the block is idle; each
// write re-arms the parser and the copy engine for a new stream.
// A parser accepts bytes whenever its four-entry command queue has room;
// marker and token-low bytes produce no command.
// The copy engine moves a literal from queue to output register through
// its fetch and emit states, and each byte of a copy through a history
// read and an emit, as the single-port window memory has a registered read.
// Reset clears all control state and the output size, which leaves the
// stream complete until the first configuration write. Once the size is
// reached, further bytes are accepted and dropped. A stall on dout.ready
// holds the output register, then the engine, then fills the queue, and
// finally drops comp.ready.
module lzss_stream_decompressor (
	input  logic                              clk,
	input  logic                              arst_n,
	lzss_in_if.sink                           comp,
	lzss_out_if.source                        dout,
	input  logic                              cfg_we,
	input  logic [lzss_pkg::SIZE_BITS-1:0]    cfg_wdata
);

	logic               push;
	lzss_pkg::cmd_t     push_cmd;
	logic               full;
	logic               pop;
	lzss_pkg::cmd_t     head;
	logic               empty;

	lzss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (cfg_we),
		.comp     (comp),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	lzss_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (cfg_we),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	lzss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.dout      (dout)
	);

endmodule
